### hw/rtl/wsae_pkg.sv
// ----------------------------------------------------------------------------
// wsae_pkg: shared types and constants of the audio stream extractor
// Result kinds, the entry passed from the front to the back, and the
// character tables for the key and end-of-turn matchers.
// ----------------------------------------------------------------------------
package wsae_pkg;

  typedef enum logic [1:0] {
    EV_PCM   = 2'd0,
    EV_PONG  = 2'd1,
    EV_CLOSE = 2'd2,
    EV_TURN  = 2'd3
  } ev_kind_e;

  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_START = 1'b1
  } op_e;

  localparam logic [3:0] FkClose = 4'h8;
  localparam logic [3:0] FkPing  = 4'h9;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [3:0] TurnLen = 4'd12;
  localparam logic [2:0] KeyLen  = 3'd6;

  // One request for the back: an optional clear of the turn state, or up to
  // three PCM bytes followed by at most one other event.
  typedef struct packed {
    logic           clr;
    logic [1:0]     pcm_cnt;
    logic [2:0][7:0] pcm_b;
    logic           has_evt;
    ev_kind_e       evt_kind;
  } wsae_entry_t;

  function automatic logic [7:0] turn_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "t";
      4'd1:    ch = "u";
      4'd2:    ch = "r";
      4'd3:    ch = "n";
      4'd4:    ch = "C";
      4'd5:    ch = "o";
      4'd6:    ch = "m";
      4'd7:    ch = "p";
      4'd8:    ch = "l";
      4'd9:    ch = "e";
      4'd10:   ch = "t";
      4'd11:   ch = "e";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] key_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h22;
      3'd1:    ch = "d";
      3'd2:    ch = "a";
      3'd3:    ch = "t";
      3'd4:    ch = "a";
      3'd5:    ch = 8'h22;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Base64 alphabet lookup: {valid, value}.
  function automatic logic [6:0] b64_decode(input logic [7:0] c);
    logic [7:0] t;
    logic [6:0] r;
    t = 8'h00;
    r = 7'h00;
    if (c >= "A" && c <= "Z") begin
      t = c - 8'd65;
      r = {1'b1, t[5:0]};
    end else if (c >= "a" && c <= "z") begin
      t = c - 8'd71;
      r = {1'b1, t[5:0]};
    end else if (c >= "0" && c <= "9") begin
      t = c + 8'd4;
      r = {1'b1, t[5:0]};
    end else if (c == "+") begin
      r = {1'b1, 6'd62};
    end else if (c == "/") begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

### hw/rtl/wsae_front.sv
// ----------------------------------------------------------------------------
// wsae_front: frame header parser, key/turn matchers and base64 decoder
// Classifies one accepted byte per cycle and builds the request for the back.
// ----------------------------------------------------------------------------
module wsae_front import wsae_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        opcode_i,
  input  logic [7:0]  rx_byte_i,
  output wsae_entry_t entry_o,
  output logic        entry_vld_o
);

  typedef enum logic [2:0] {
    PH_B0   = 3'd0,
    PH_B1   = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_PAY  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    SP_SEEK  = 2'd0,
    SP_QUOTE = 2'd1,
    SP_STR   = 2'd2
  } sphase_e;

  localparam logic [7:0] QuoteChar = 8'h22;

  phase_e      phase_q, phase_d;
  sphase_e     sphase_q, sphase_d;
  logic [3:0]  ext_q, ext_d;
  logic [3:0]  fkind_q, fkind_d;
  logic        mask_q, mask_d;
  logic [63:0] pl_q, pl_d;
  logic [3:0]  tpos_q, tpos_d;
  logic [2:0]  kpos_q, kpos_d;
  logic [17:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        audio_q, audio_d;
  logic        tfin_q, tfin_d;

  wsae_entry_t ent;
  logic        hd;
  logic [63:0] hd_pl;
  logic        scan_en;
  logic [6:0]  len7;
  logic [3:0]  tnext;
  logic [2:0]  knext;
  logic [6:0]  b64;
  logic [23:0] full_word;
  logic        finish;

  always_comb begin
    phase_d  = phase_q;
    sphase_d = sphase_q;
    ext_d    = ext_q;
    fkind_d  = fkind_q;
    mask_d   = mask_q;
    pl_d     = pl_q;
    tpos_d   = tpos_q;
    kpos_d   = kpos_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    audio_d  = audio_q;
    tfin_d   = tfin_q;
    ent      = '0;
    hd       = 1'b0;
    hd_pl    = pl_q;
    scan_en  = 1'b0;
    len7     = rx_byte_i[6:0];
    tnext    = 4'd0;
    knext    = 3'd0;
    b64      = b64_decode(rx_byte_i);
    full_word = {acc_q, b64[5:0]};
    finish   = 1'b0;

    if (opcode_i == OP_START) begin
      // Clear the per-turn state; framing carries on.
      tpos_d   = 4'd0;
      kpos_d   = 3'd0;
      sphase_d = SP_SEEK;
      acc_d    = '0;
      cnt_d    = 2'd0;
      audio_d  = 1'b0;
      tfin_d   = 1'b0;
      ent.clr  = 1'b1;
    end else begin
      case (phase_q)
        PH_B0: begin
          fkind_d = rx_byte_i[3:0];
          phase_d = PH_B1;
        end
        PH_B1: begin
          mask_d = rx_byte_i[7];
          if (len7 == 7'd126 || len7 == 7'd127) begin
            pl_d    = '0;
            ext_d   = (len7 == 7'd126) ? 4'd2 : 4'd8;
            phase_d = PH_EXT;
          end else begin
            pl_d = {57'd0, len7};
            if (rx_byte_i[7]) begin
              ext_d   = 4'd4;
              phase_d = PH_MASK;
            end else begin
              hd    = 1'b1;
              hd_pl = {57'd0, len7};
            end
          end
        end
        PH_EXT: begin
          pl_d = {pl_q[55:0], rx_byte_i};
          if (ext_q != 4'd0) ext_d = ext_q - 4'd1;
          if (ext_d == 4'd0) begin
            if (mask_q) begin
              ext_d   = 4'd4;
              phase_d = PH_MASK;
            end else begin
              hd    = 1'b1;
              hd_pl = pl_d;
            end
          end
        end
        PH_MASK: begin
          if (ext_q != 4'd0) ext_d = ext_q - 4'd1;
          if (ext_d == 4'd0) hd = 1'b1;
        end
        PH_PAY: begin
          if (pl_q != 64'd0) pl_d = pl_q - 64'd1;
          if (fkind_q == FkPing) begin
            if (pl_d == 64'd0) begin
              ent.has_evt  = 1'b1;
              ent.evt_kind = EV_PONG;
            end
          end else if (fkind_q != FkClose && !tfin_q) begin
            scan_en = 1'b1;
          end
          if (pl_d == 64'd0) phase_d = PH_B0;
        end
        default: phase_d = PH_B0;
      endcase

      if (hd) begin
        if (fkind_q == FkClose) begin
          ent.has_evt  = 1'b1;
          ent.evt_kind = EV_CLOSE;
        end
        if (hd_pl == 64'd0) begin
          phase_d = PH_B0;
          if (fkind_q == FkPing) begin
            ent.has_evt  = 1'b1;
            ent.evt_kind = EV_PONG;
          end
        end else begin
          phase_d = PH_PAY;
        end
      end

      if (scan_en) begin
        // End-of-turn matcher runs on every scanned byte.
        if (rx_byte_i == turn_char(tpos_q)) tnext = tpos_q + 4'd1;
        else tnext = (rx_byte_i == turn_char(4'd0)) ? 4'd1 : 4'd0;
        if (tnext == TurnLen) begin
          tpos_d = 4'd0;
          finish = audio_q;
        end else begin
          tpos_d = tnext;
        end

        case (sphase_q)
          SP_SEEK: begin
            if (rx_byte_i == key_char(kpos_q)) knext = kpos_q + 3'd1;
            else knext = (rx_byte_i == key_char(3'd0)) ? 3'd1 : 3'd0;
            if (knext == KeyLen) begin
              sphase_d = SP_QUOTE;
              kpos_d   = 3'd0;
            end else begin
              kpos_d = knext;
            end
          end
          SP_QUOTE: begin
            if (rx_byte_i == QuoteChar) begin
              sphase_d = SP_STR;
              acc_d    = '0;
              cnt_d    = 2'd0;
            end
          end
          SP_STR: begin
            if (rx_byte_i == QuoteChar) begin
              // Flush the partial group.
              if (cnt_q == 2'd2) begin
                ent.pcm_cnt  = 2'd1;
                ent.pcm_b[0] = acc_q[11:4];
              end else if (cnt_q == 2'd3) begin
                ent.pcm_cnt  = 2'd2;
                ent.pcm_b[0] = acc_q[17:10];
                ent.pcm_b[1] = acc_q[9:2];
              end
              acc_d    = '0;
              cnt_d    = 2'd0;
              sphase_d = SP_SEEK;
            end else if (b64[6]) begin
              if (cnt_q == 2'd3) begin
                ent.pcm_cnt  = 2'd3;
                ent.pcm_b[0] = full_word[23:16];
                ent.pcm_b[1] = full_word[15:8];
                ent.pcm_b[2] = full_word[7:0];
                acc_d        = '0;
                cnt_d        = 2'd0;
              end else begin
                acc_d = {acc_q[11:0], b64[5:0]};
                cnt_d = cnt_q + 2'd1;
              end
            end
            if (ent.pcm_cnt != 2'd0) audio_d = 1'b1;
          end
          default: sphase_d = SP_SEEK;
        endcase

        if (finish) begin
          tfin_d       = 1'b1;
          ent.has_evt  = 1'b1;
          ent.evt_kind = EV_TURN;
        end
      end
    end
  end

  assign entry_o     = ent;
  assign entry_vld_o = accept_i && (ent.clr || ent.has_evt || ent.pcm_cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_B0;
      sphase_q <= SP_SEEK;
      ext_q    <= '0;
      fkind_q  <= '0;
      mask_q   <= 1'b0;
      pl_q     <= '0;
      tpos_q   <= '0;
      kpos_q   <= '0;
      acc_q    <= '0;
      cnt_q    <= '0;
      audio_q  <= 1'b0;
      tfin_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      sphase_q <= sphase_d;
      ext_q    <= ext_d;
      fkind_q  <= fkind_d;
      mask_q   <= mask_d;
      pl_q     <= pl_d;
      tpos_q   <= tpos_d;
      kpos_q   <= kpos_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      audio_q  <= audio_d;
      tfin_q   <= tfin_d;
    end
  end

endmodule

### hw/rtl/wsae_queue.sv
// ----------------------------------------------------------------------------
// wsae_queue: short request queue between front and back
// Holds classified requests so that either side can stall on its own.
// ----------------------------------------------------------------------------
module wsae_queue import wsae_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_i,
  input  wsae_entry_t wr_entry_i,
  input  logic        rd_i,
  output wsae_entry_t head_o,
  output logic        head_vld_o,
  output logic        full_o
);

  wsae_entry_t           mem_q [QDepth];
  logic [QAw-1:0]        wptr_q, rptr_q;
  logic [QCntW-1:0]      cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wptr_q] <= wr_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) wptr_q <= wptr_q + QAw'(1);
      if (rd_i) rptr_q <= rptr_q + QAw'(1);
      case ({wr_i, rd_i})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head_o     = mem_q[rptr_q];
  assign head_vld_o = (cnt_q != '0);
  assign full_o     = (cnt_q == QCntW'(QDepth));

endmodule

### hw/rtl/wsae_back.sv
// ----------------------------------------------------------------------------
// wsae_back: result sequencer with sample peak tracking
// Emits one result per cycle from the head request to a free output register.
// ----------------------------------------------------------------------------
module wsae_back import wsae_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  wsae_entry_t head_i,
  input  logic        head_vld_i,
  output logic        deq_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [1:0]  event_kind_o,
  output logic [7:0]  pcm_byte_o,
  output logic [15:0] peak_level_o,
  output logic        last_o
);

  logic [1:0]  idx_q, idx_d;
  logic [7:0]  held_q, held_d;
  logic        heldv_q, heldv_d;
  logic [15:0] peak_q, peak_d;
  logic        ovld_q, ovld_d;
  ev_kind_e    okind_q, okind_d;
  logic [7:0]  obyte_q, obyte_d;
  logic [15:0] opeak_q, opeak_d;
  logic        olast_q, olast_d;

  logic        out_free;
  logic        emit;
  logic [2:0]  total;
  logic        is_last;
  logic        is_pcm;
  logic [7:0]  pb;
  logic [15:0] raw, mag;

  always_comb begin
    idx_d    = idx_q;
    held_d   = held_q;
    heldv_d  = heldv_q;
    peak_d   = peak_q;
    okind_d  = okind_q;
    obyte_d  = obyte_q;
    opeak_d  = opeak_q;
    olast_d  = olast_q;
    deq_o    = 1'b0;
    emit     = 1'b0;
    out_free = !ovld_q || pop_i;
    total    = {1'b0, head_i.pcm_cnt} + {2'b00, head_i.has_evt};
    is_last  = ({1'b0, idx_q} + 3'd1) == total;
    is_pcm   = idx_q < head_i.pcm_cnt;
    pb       = head_i.pcm_b[idx_q];
    raw      = {pb, held_q};
    mag      = raw[15] ? (~raw + 16'd1) : raw;

    if (head_vld_i && head_i.clr) begin
      held_d  = '0;
      heldv_d = 1'b0;
      peak_d  = '0;
      deq_o   = 1'b1;
    end else if (head_vld_i && out_free) begin
      emit = 1'b1;
      if (is_pcm) begin
        // Pair bytes into little-endian samples and track the peak.
        if (!heldv_q) begin
          held_d  = pb;
          heldv_d = 1'b1;
        end else begin
          heldv_d = 1'b0;
          if (mag > peak_q) peak_d = mag;
        end
        okind_d = EV_PCM;
        obyte_d = pb;
      end else begin
        okind_d = head_i.evt_kind;
        obyte_d = '0;
      end
      opeak_d = peak_d;
      olast_d = is_last;
      if (is_last) begin
        idx_d = 2'd0;
        deq_o = 1'b1;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end

    if (emit) ovld_d = 1'b1;
    else if (pop_i) ovld_d = 1'b0;
    else ovld_d = ovld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      held_q  <= '0;
      heldv_q <= 1'b0;
      peak_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      held_q  <= held_d;
      heldv_q <= heldv_d;
      peak_q  <= peak_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q <= okind_d;
    obyte_q <= obyte_d;
    opeak_q <= opeak_d;
    olast_q <= olast_d;
  end

  assign empty_o      = !ovld_q;
  assign event_kind_o = okind_q;
  assign pcm_byte_o   = obyte_q;
  assign peak_level_o = opeak_q;
  assign last_o       = olast_q;

endmodule

### hw/rtl/websocket_audio_stream_extractor.sv
// ----------------------------------------------------------------------------
// websocket_audio_stream_extractor: WebSocket deframer with audio extraction
// Parses server frames, decodes the base64 audio string into PCM bytes and
// reports pong requests, close frames and end of turn.
// ----------------------------------------------------------------------------
// The block takes one server byte (or a start-turn request) per cycle
// whenever full is low, and hands out results one per cycle whenever the
// consumer pops. A byte is classified in the cycle it is accepted: the front
// tracks the frame header, the "data" key, the end-of-turn word and the
// base64 group, and turns the byte into one request holding up to four
// results (three PCM bytes, then a pong, close or turn-complete event).
// Bytes that cause no result and no state change in the back leave no
// request. Requests wait in a four-entry queue; the back drains the head
// request into the output register at one result per cycle while that
// register is free, pairing PCM bytes into little-endian samples for the
// running peak. A start-turn request clears the front's turn state at
// once and, as its own request, clears the held byte and peak in the back,
// in order with the results before it. Full rises only when the queue
// holds four requests, which needs the consumer to hold pop low: a base64
// group gives three results per four bytes, so with pop held high the
// back keeps pace with the byte stream. The last result of each byte
// carries last = 1. There is no clearing pass.
// ----------------------------------------------------------------------------
module websocket_audio_stream_extractor import wsae_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        opcode_i,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  event_kind_o,
  output logic [7:0]  pcm_byte_o,
  output logic [15:0] peak_level_o,
  output logic        last_o
);

  wsae_entry_t f_entry;
  logic        f_vld;
  wsae_entry_t q_head;
  logic        q_vld;
  logic        q_full;
  logic        b_deq;
  logic        accept;

  // Hold input whenever the queue has no room.
  assign accept = push && !q_full;
  assign full   = q_full;

  wsae_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .opcode_i    (opcode_i),
    .rx_byte_i   (rx_byte_i),
    .entry_o     (f_entry),
    .entry_vld_o (f_vld)
  );

  wsae_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (f_vld),
    .wr_entry_i (f_entry),
    .rd_i       (b_deq),
    .head_o     (q_head),
    .head_vld_o (q_vld),
    .full_o     (q_full)
  );

  wsae_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .head_vld_i   (q_vld),
    .deq_o        (b_deq),
    .pop_i        (pop),
    .empty_o      (empty),
    .event_kind_o (event_kind_o),
    .pcm_byte_o   (pcm_byte_o),
    .peak_level_o (peak_level_o),
    .last_o       (last_o)
  );

endmodule

### hw/rtl/wsae_checker.sv
// ----------------------------------------------------------------------------
// wsae_checker: port-level checks for the audio stream extractor
// Watches the result side of the top level over time.
// ----------------------------------------------------------------------------
module wsae_checker import wsae_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  event_kind_o,
  input logic [7:0]  pcm_byte_o,
  input logic [15:0] peak_level_o,
  input logic        last_o
);

  // A waiting result that is not taken stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(event_kind_o) && $stable(pcm_byte_o)
      && $stable(peak_level_o) && $stable(last_o))
    else $error("result changed while stalled");

  a_peak_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> peak_level_o <= 16'd32768)
    else $error("peak out of range");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && event_kind_o != EV_PCM |-> pcm_byte_o == 8'd0)
    else $error("pcm byte set on an event result");

  // Turn complete always closes the results of its byte.
  a_turn_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && event_kind_o == EV_TURN |-> last_o)
    else $error("turn complete not last");

endmodule

bind websocket_audio_stream_extractor wsae_checker u_wsae_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .event_kind_o (event_kind_o),
  .pcm_byte_o   (pcm_byte_o),
  .peak_level_o (peak_level_o),
  .last_o       (last_o)
);

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression for the WebSocket audio stream extractor
// Feeds frames of server bytes and start-turn requests through the input
// queue interface and compares every popped result, field by field, against
// a cycle-free model of the deframer, base64 decoder and peak tracker.
// ----------------------------------------------------------------------------
module tb;
  import wsae_pkg::*;

  // Frame kinds used by the stimulus besides ping and close from the package.
  localparam logic [3:0] FkCont = 4'h0;
  localparam logic [3:0] FkText = 4'h1;
  localparam logic [3:0] FkBin  = 4'h2;

  // Length codes of the second header byte.
  localparam logic [6:0] Len16   = 7'd126;
  localparam logic [6:0] Len64   = 7'd127;
  localparam int         LenMax7 = 125;
  localparam logic [3:0] MaskBytes = 4'd4;

  localparam logic [95:0] TurnWord = "turnComplete";
  localparam int          TurnLen  = 12;
  localparam logic [47:0] KeyWord  = "\"data\"";
  localparam int          KeyLen   = 6;
  localparam logic [7:0]  Quote    = 8'h22;

  localparam int TailCycles = 32;

  typedef enum logic [2:0] {HDR_B0, HDR_B1, HDR_EXT, HDR_MASK, HDR_PAY} hdr_e;
  typedef enum logic [1:0] {STR_SEEK, STR_OPEN, STR_IN} str_e;

  typedef struct packed {
    ev_kind_e    kind;
    logic [7:0]  pcm;
    logic [15:0] peak;
    logic        fin;
  } result_t;

  // One pending request: the fields to drive, the idle cycles to wait
  // before it, and whether to hold it until the block has drained.
  typedef struct {
    op_e        op;
    logic [7:0] data;
    int         gap;
    bit         drain;
  } req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        opcode_i = OP_BYTE;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  event_kind_o;
  logic [7:0]  pcm_byte_o;
  logic [15:0] peak_level_o;
  logic        last_o;

  websocket_audio_stream_extractor DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .opcode_i     (opcode_i),
    .rx_byte_i    (rx_byte_i),
    .empty        (empty),
    .pop          (pop),
    .event_kind_o (event_kind_o),
    .pcm_byte_o   (pcm_byte_o),
    .peak_level_o (peak_level_o),
    .last_o       (last_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Deframer model: framing, matchers, decoder, held low byte and peak
  // --------------------------------------------------------------------------
  hdr_e        hdr_st      = HDR_B0;
  logic [3:0]  ext_left    = '0;
  logic [3:0]  fr_kind     = '0;
  logic        masked      = 1'b0;
  logic [63:0] pay_left    = '0;
  logic [3:0]  turn_pos    = '0;
  logic [3:0]  key_pos     = '0;
  str_e        str_st      = STR_SEEK;
  logic [17:0] acc         = '0;
  logic [1:0]  acc_n       = '0;
  logic        heard_audio = 1'b0;
  logic        turn_done   = 1'b0;
  logic [7:0]  lo_byte     = '0;
  logic        lo_ok       = 1'b0;
  logic [15:0] peak        = '0;

  result_t step_res[$];  // results of the request being modeled
  result_t want_q[$];    // results still owed by the block, oldest first

  task automatic note(input ev_kind_e k, input logic [7:0] b);
    result_t r;
    r.kind = k;
    r.pcm  = b;
    r.peak = peak;
    r.fin  = 1'b0;
    step_res.push_back(r);
  endtask

  // Pair bytes into little-endian samples; the peak is taken after the byte.
  task automatic note_pcm(input logic [7:0] b);
    logic [15:0] raw;
    logic [16:0] mag;
    if (!lo_ok) begin
      lo_byte = b;
      lo_ok   = 1'b1;
    end else begin
      raw = {b, lo_byte};
      mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
      if (mag > {1'b0, peak}) peak = mag[15:0];
      lo_ok = 1'b0;
    end
    note(EV_PCM, b);
  endtask

  // Advance a word matcher; a mismatch restarts on the first character.
  function automatic logic [3:0] word_step(input logic [3:0] pos, input logic [7:0] c,
                                           input logic [95:0] word, input int len);
    logic [7:0] want_c;
    logic [7:0] head_c;
    want_c = word[8*(len-1-pos) +: 8];
    head_c = word[8*(len-1) +: 8];
    if (c == want_c) return pos + 4'd1;
    return (c == head_c) ? 4'd1 : 4'd0;
  endfunction

  function automatic int b64_val(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  task automatic scan_payload(input logic [7:0] c);
    bit          finish;
    int          n_prior;
    int          v;
    logic [23:0] grp;
    finish = 1'b0;
    turn_pos = word_step(turn_pos, c, TurnWord, TurnLen);
    if (turn_pos >= TurnLen) begin
      turn_pos = '0;
      finish   = heard_audio;  // audio must come from an earlier byte
    end
    case (str_st)
      STR_SEEK: begin
        key_pos = word_step(key_pos, c, {48'd0, KeyWord}, KeyLen);
        if (key_pos >= KeyLen) begin
          str_st  = STR_OPEN;
          key_pos = '0;
        end
      end
      STR_OPEN: begin
        if (c == Quote) begin
          str_st = STR_IN;
          acc    = '0;
          acc_n  = '0;
        end
      end
      default: begin
        n_prior = step_res.size();
        if (c == Quote) begin
          // flush: two characters give one byte, three give two
          if (acc_n == 2'd2) begin
            note_pcm(acc[11:4]);
          end else if (acc_n == 2'd3) begin
            note_pcm(acc[17:10]);
            note_pcm(acc[9:2]);
          end
          acc    = '0;
          acc_n  = '0;
          str_st = STR_SEEK;
        end else begin
          v = b64_val(c);
          if (v >= 0) begin
            if (acc_n == 2'd3) begin
              grp = {acc, v[5:0]};
              note_pcm(grp[23:16]);
              note_pcm(grp[15:8]);
              note_pcm(grp[7:0]);
              acc   = '0;
              acc_n = '0;
            end else begin
              acc   = {acc[11:0], v[5:0]};
              acc_n = acc_n + 2'd1;
            end
          end
        end
        if (step_res.size() > n_prior) heard_audio = 1'b1;
      end
    endcase
    if (finish) begin
      turn_done = 1'b1;
      note(EV_TURN, 8'h00);
    end
  endtask

  task automatic header_end();
    if (fr_kind == FkClose) note(EV_CLOSE, 8'h00);
    if (pay_left == 0) begin
      hdr_st = HDR_B0;
      if (fr_kind == FkPing) note(EV_PONG, 8'h00);
    end else begin
      hdr_st = HDR_PAY;
    end
  endtask

  // Model one accepted request and queue the results it owes.
  task automatic deframe_step(input op_e op, input logic [7:0] c);
    result_t r;
    step_res.delete();
    if (op == OP_START) begin
      turn_pos    = '0;
      key_pos     = '0;
      str_st      = STR_SEEK;
      acc         = '0;
      acc_n       = '0;
      heard_audio = 1'b0;
      turn_done   = 1'b0;
      lo_byte     = '0;
      lo_ok       = 1'b0;
      peak        = '0;
    end else begin
      case (hdr_st)
        HDR_B0: begin
          fr_kind = c[3:0];
          hdr_st  = HDR_B1;
        end
        HDR_B1: begin
          masked = c[7];
          if (c[6:0] == Len16 || c[6:0] == Len64) begin
            pay_left = '0;
            ext_left = (c[6:0] == Len16) ? 4'd2 : 4'd8;
            hdr_st   = HDR_EXT;
          end else begin
            pay_left = {57'd0, c[6:0]};
            if (masked) begin
              ext_left = MaskBytes;
              hdr_st   = HDR_MASK;
            end else begin
              header_end();
            end
          end
        end
        HDR_EXT: begin
          pay_left = {pay_left[55:0], c};
          if (ext_left != 0) ext_left = ext_left - 4'd1;
          if (ext_left == 0) begin
            if (masked) begin
              ext_left = MaskBytes;
              hdr_st   = HDR_MASK;
            end else begin
              header_end();
            end
          end
        end
        HDR_MASK: begin
          if (ext_left != 0) ext_left = ext_left - 4'd1;
          if (ext_left == 0) header_end();
        end
        HDR_PAY: begin
          if (pay_left != 0) pay_left = pay_left - 64'd1;
          if (fr_kind == FkPing) begin
            if (pay_left == 0) note(EV_PONG, 8'h00);
          end else if (fr_kind != FkClose && !turn_done) begin
            scan_payload(c);
          end
          if (pay_left == 0) hdr_st = HDR_B0;
        end
        default: hdr_st = HDR_B0;
      endcase
    end
    if (step_res.size() > 0) begin
      r = step_res.pop_back();
      r.fin = 1'b1;
      step_res.push_back(r);
    end
    foreach (step_res[i]) want_q.push_back(step_res[i]);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------
  req_t pend_q[$];
  bit   drain_next = 1'b0;
  int   src_calm   = 0;
  int   sink_calm  = 0;

  // Draw idle cycles for one request or result; now and then start a
  // stretch with no idling at all.
  function automatic int draw_wait(inout int calm, input int pct);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(15, 60);
      return 0;
    end
    return ($urandom_range(0, 99) < pct) ? $urandom_range(0, 16) : 0;
  endfunction

  task automatic add_req(input op_e op, input logic [7:0] b);
    req_t r;
    r.op    = op;
    r.data  = b;
    r.gap   = draw_wait(src_calm, 30);
    r.drain = drain_next;
    drain_next = 1'b0;
    pend_q.push_back(r);
  endtask

  task automatic put_str(ref logic [7:0] q[$], input string s);
    int i;
    for (i = 0; i < s.len(); i++) q.push_back(s[i]);
  endtask

  function automatic logic [7:0] b64_char(input int idx);
    if (idx < 26) return 8'(int'("A") + idx);
    if (idx < 52) return 8'(int'("a") + idx - 26);
    if (idx < 62) return 8'(int'("0") + idx - 52);
    return (idx == 62) ? "+" : "/";
  endfunction

  // Mostly alphabet characters, with padding and stray bytes mixed in.
  task automatic put_b64(ref logic [7:0] q[$], input int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 86) q.push_back(b64_char($urandom_range(0, 63)));
      else if (sel < 93) q.push_back("=");
      else q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic put_segment(ref logic [7:0] q[$]);
    int    sel;
    int    n;
    string w;
    sel = $urandom_range(0, 9);
    if (sel <= 4) begin
      // key, separator, quoted audio; sometimes left open across frames
      put_str(q, "\"data\"");
      if ($urandom_range(0, 3) == 0) put_str(q, ": ");
      else q.push_back(":");
      q.push_back(Quote);
      put_b64(q, $urandom_range(0, 12));
      if ($urandom_range(0, 9) != 0) q.push_back(Quote);
    end else if (sel == 5) begin
      put_str(q, "turnComplete");
    end else if (sel == 6) begin
      // cut a word short and break it with a stray byte
      w = $urandom_range(0, 1) ? "\"data\"" : "turnComplete";
      n = $urandom_range(1, w.len() - 1);
      put_str(q, w.substr(0, n - 1));
      q.push_back(8'($urandom_range(0, 255)));
    end else if (sel == 7) begin
      // matches that must restart on their first character
      if ($urandom_range(0, 1)) put_str(q, "\"\"data\"\"");
      else put_str(q, "turnCturnComplete");
    end else begin
      repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Wrap a payload in a header with a random length form and mask; slip
  // start-turn requests in between payload bytes now and then.
  task automatic add_frame(input logic [3:0] kind, ref logic [7:0] body[$]);
    int          len;
    int          sel;
    int          i;
    bit          mk;
    logic [63:0] len64;
    len   = body.size();
    len64 = len;
    sel   = $urandom_range(0, 99);
    mk    = ($urandom_range(0, 3) == 0);
    add_req(OP_BYTE, {4'($urandom_range(0, 15)), kind});
    if (sel < 80 && len <= LenMax7) begin
      add_req(OP_BYTE, {mk, 7'(len)});
    end else if (sel < 92) begin
      add_req(OP_BYTE, {mk, Len16});
      add_req(OP_BYTE, len64[15:8]);
      add_req(OP_BYTE, len64[7:0]);
    end else begin
      add_req(OP_BYTE, {mk, Len64});
      for (i = 7; i >= 0; i--) add_req(OP_BYTE, len64[8*i +: 8]);
    end
    if (mk) repeat (MaskBytes) add_req(OP_BYTE, 8'($urandom_range(0, 255)));
    foreach (body[j]) begin
      if ($urandom_range(0, 49) == 0) add_req(OP_START, 8'($urandom_range(0, 255)));
      add_req(OP_BYTE, body[j]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver, monitor and checker
  // --------------------------------------------------------------------------
  bit took_req = 1'b0;  // a request was accepted at the last rising edge
  bit took_res = 1'b0;  // a result was accepted at the last rising edge
  int waited   = 0;
  int stall    = 0;
  int errs     = 0;
  int n_req    = 0;
  int n_start  = 0;
  int n_res    = 0;
  int kind_cnt[4];
  int peak_hi  = 0;

  // Sample both handshakes at the rising edge: check the popped result
  // first, then model the request taken in the same cycle.
  always @(posedge clk_i) begin : mon
    result_t exp_r;
    if (rst_ni) begin
      if (pop && !empty) begin
        took_res = 1'b1;
        n_res++;
        kind_cnt[event_kind_o]++;
        if (peak_level_o > peak_hi) peak_hi = peak_level_o;
        if (want_q.size() == 0) begin
          errs++;
          $error("unexpected result: event_kind %0d pcm_byte %0h peak_level %0d last %0b",
                 event_kind_o, pcm_byte_o, peak_level_o, last_o);
        end else begin
          exp_r = want_q.pop_front();
          if (event_kind_o !== exp_r.kind) begin
            errs++;
            $error("event_kind: expected %0d, got %0d", exp_r.kind, event_kind_o);
          end
          if (pcm_byte_o !== exp_r.pcm) begin
            errs++;
            $error("pcm_byte: expected %0h, got %0h", exp_r.pcm, pcm_byte_o);
          end
          if (peak_level_o !== exp_r.peak) begin
            errs++;
            $error("peak_level: expected %0d, got %0d", exp_r.peak, peak_level_o);
          end
          if (last_o !== exp_r.fin) begin
            errs++;
            $error("last: expected %0b, got %0b", exp_r.fin, last_o);
          end
        end
      end
      if (push && !full) begin
        took_req = 1'b1;
        n_req++;
        if (opcode_i == OP_START) n_start++;
        deframe_step(op_e'(opcode_i), rx_byte_i);
      end
    end
  end

  // Drive requests at the falling edge. Hold a request until it is taken;
  // then wait its idle cycles, or for a drained block where it asks for one.
  always @(negedge clk_i) begin : drv
    req_t nxt;
    if (rst_ni) begin
      if (!push || took_req) begin
        if (pend_q.size() == 0) begin
          push <= 1'b0;
        end else if (waited < pend_q[0].gap || (pend_q[0].drain && want_q.size() != 0)) begin
          waited++;
          push <= 1'b0;
        end else begin
          nxt = pend_q.pop_front();
          opcode_i  <= nxt.op;
          rx_byte_i <= nxt.data;
          push      <= 1'b1;
          waited = 0;
        end
      end
      took_req = 1'b0;
    end
  end

  // Stall the result side: draw a fresh wait after every result taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (took_res) begin
        stall    = draw_wait(sink_calm, 50);
        took_res = 1'b0;
      end
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : run
    logic [7:0] body[$];
    logic [3:0] kind;
    int         sel;

    // Ping with no payload: pong at the end of the header.
    add_req(OP_BYTE, {4'h8, FkPing});
    add_req(OP_BYTE, 8'h00);
    // Close with one payload byte: reported at the header, payload skipped.
    add_req(OP_BYTE, {4'hF, FkClose});
    add_req(OP_BYTE, 8'h01);
    add_req(OP_BYTE, 8'hFF);
    // Masked text frame: skip the key, decode the most negative sample,
    // ignore padding, and flush three pending characters at the quote.
    put_str(body, "\"data\"\"AIAA=//8\"");
    add_req(OP_BYTE, {4'h0, FkText});
    add_req(OP_BYTE, {1'b1, 7'(body.size())});
    add_req(OP_BYTE, 8'hFF);
    add_req(OP_BYTE, 8'h00);
    add_req(OP_BYTE, 8'hA5);
    add_req(OP_BYTE, 8'h5A);
    foreach (body[i]) add_req(OP_BYTE, body[i]);
    add_req(OP_START, 8'hFF);

    // Random frames: mostly audio payloads, plus control frames, turn ends,
    // odd frame kinds and stray start-turn requests.
    drain_next = 1'b1;
    while (pend_q.size() < 365) begin
      body.delete();
      if ($urandom_range(0, 29) == 0) drain_next = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        repeat ($urandom_range(1, 3)) put_segment(body);
        case ($urandom_range(0, 2))
          0:       kind = FkText;
          1:       kind = FkBin;
          default: kind = FkCont;
        endcase
        add_frame(kind, body);
      end else if (sel < 62) begin
        repeat ($urandom_range(0, 3)) body.push_back(8'($urandom_range(0, 255)));
        add_frame(FkPing, body);
      end else if (sel < 68) begin
        repeat ($urandom_range(0, 2)) body.push_back(8'($urandom_range(0, 255)));
        add_frame(FkClose, body);
      end else if (sel < 76) begin
        repeat ($urandom_range(1, 2)) put_segment(body);
        add_frame(4'($urandom_range(0, 15)), body);
      end else if (sel < 86) begin
        add_req(OP_START, 8'($urandom_range(0, 255)));
      end else begin
        // audio, then the end-of-turn word: either after the string, or
        // inside it so that its last letter also completes a group
        put_str(body, "\"data\":\"");
        repeat (4) body.push_back(b64_char($urandom_range(0, 63)));
        if ($urandom_range(0, 1)) put_str(body, "turnComplete\"");
        else put_str(body, "\"turnComplete");
        add_frame(FkText, body);
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every request taken, every result back, then a quiet tail.
    while (pend_q.size() != 0 || push || want_q.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (want_q.size() != 0) begin
      errs++;
      $error("%0d results never arrived", want_q.size());
    end

    $display("covered %0d requests (%0d turn starts) and %0d results", n_req, n_start, n_res);
    $display("  pcm %0d, pong %0d, close %0d, turn complete %0d, highest peak %0d",
             kind_cnt[EV_PCM], kind_cnt[EV_PONG], kind_cnt[EV_CLOSE], kind_cnt[EV_TURN],
             peak_hi);
    if (errs == 0) begin
      $display("websocket_audio_stream_extractor regression: pass");
    end else begin
      $display("websocket_audio_stream_extractor regression: fail");
    end
    $finish;
  end

  // Stop a hung run well past the slowest legal completion.
  initial begin
    #5_000_000;
    $display("websocket_audio_stream_extractor regression: fail");
    $finish;
  end

endmodule

### websocket_audio_stream_extractor.f
hw/rtl/wsae_pkg.sv
hw/rtl/wsae_front.sv
hw/rtl/wsae_queue.sv
hw/rtl/wsae_back.sv
hw/rtl/websocket_audio_stream_extractor.sv
hw/rtl/wsae_checker.sv
test/tb.sv
